### hdl/tape_pulse_record_play_top_defines.svh
`ifndef TAPE_PULSE_RECORD_PLAY_TOP_DEFINES_SVH
`define TAPE_PULSE_RECORD_PLAY_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TPRP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TPRP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tprp_pkg.sv
package tprp_pkg;

  // Default number of 16-bit pulse slots in the store.
  localparam int STORE_DEPTH_DEF = 65536;

  // Longest pulse that fits one slot.
  localparam logic [15:0] PULSE_MAX = 16'hFFFF;

  // Item commands.
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_REWIND = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BACK = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_PAIRS,
    S_ROOM,
    S_PUT_SEL,
    S_PUT_LO,
    S_PUT_ZERO,
    S_OFFSET,
    S_PRD,
    S_PSTEP,
    S_OUT
  } state_t;

  // Value written into a slot.
  typedef enum logic [1:0] {
    PUT_MAX,
    PUT_ZERO,
    PUT_REM
  } put_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       load_len;
    logic       load_pairs;
    logic       put;
    put_sel_t   put_sel;
    logic       sub_rem;
    logic       step;
    logic       set_off;
    logic       park;
    logic       rewind;
    logic       load_out;
    logic [1:0] out_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] item_cmd;
    logic       rec_mode;
    logic       back;
    logic       past_end;
    logic       lvl_diff;
    logic       room_ok;
    logic       rem_big;
    logic       step_ok;
  } dp_stat_t;

endpackage

### hdl/tprp_dp.sv
`include "tape_pulse_record_play_top_defines.svh"

module tprp_dp #(
  parameter int STORE_DEPTH = tprp_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tprp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  input  logic [1:0]                     cmd,
  input  logic [31:0]                    cycle,
  input  logic                           level_in,
  output logic                           level,
  output logic                           at_end,
  output logic [1:0]                     status,
  input  tprp_pkg::dp_cmd_t              ctl,
  output tprp_pkg::dp_stat_t             stat
);
  import tprp_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int IW = $clog2(STORE_DEPTH + 1);
  localparam int NW = ((IW > 19) ? IW : 19) + 1;

  // Configuration registers.
  logic rec_mode;
  logic init_level;

  // Captured item.
  logic [1:0]  item_cmd;
  logic [31:0] item_cycle;
  logic        item_level;

  // Tape position state.
  logic [IW-1:0] ri;
  logic [IW-1:0] used;
  logic [31:0]   psc;
  logic [31:0]   total;
  logic [31:0]   off;
  logic          cur_level;

  // Pulse being recorded and its slot pair count.
  logic [31:0] rem;
  logic [16:0] pairs;

  // Pulse store with registered read.
  logic [15:0] mem [STORE_DEPTH];
  logic [15:0] rd_data;

  logic [32:0]   here;
  logic [32:0]   step_end;
  logic [31:0]   x;
  logic [16:0]   xs;
  logic [16:0]   xq;
  logic [16:0]   pairs_calc;
  logic [NW-1:0] need_w;
  logic [NW-1:0] room_sum;
  logic          room_ok;
  logic [15:0]   put_val;
  logic [IW-1:0] ri_inc;
  logic          left_odd;

  // Position checks for the current item.
  always_comb begin
    here          = {1'b0, psc} + {1'b0, off};
    step_end      = {1'b0, psc} + {17'd0, rd_data};
    stat.item_cmd = item_cmd;
    stat.rec_mode = rec_mode;
    stat.back     = {1'b0, item_cycle} < here;
    stat.past_end = item_cycle >= total;
    stat.lvl_diff = item_level != cur_level;
    stat.room_ok  = room_ok;
    stat.rem_big  = rem[31:16] != 16'd0;
    stat.step_ok  = (ri < used) && ({1'b0, item_cycle} >= step_end);
  end

  // Number of 0xFFFF,0 pairs for a long pulse: x / 65535 + 1, the quotient taken as a + carries of (a + b).
  always_comb begin
    x  = rem - 32'h0001_0000;
    xs = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    xq = {1'b0, x[31:16]} + 17'(xs >= 17'h0FFFF) + 17'(xs >= 17'h1FFFE);
    if (rem[31:16] != 16'd0) begin
      pairs_calc = xq + 17'd1;
    end else begin
      pairs_calc = 17'd0;
    end
  end

  // Room check: slots for the pulse, plus one for the closing zero pulse on finish.
  always_comb begin
    need_w   = NW'({pairs, 1'b1}) + NW'(item_cmd == CMD_FINISH);
    room_sum = NW'(ri) + need_w;
    room_ok  = room_sum <= NW'(STORE_DEPTH);
  end

  // Slot value select.
  always_comb begin
    case (ctl.put_sel)
      PUT_MAX:  put_val = PULSE_MAX;
      PUT_ZERO: put_val = 16'd0;
      PUT_REM:  put_val = rem[15:0];
      default:  put_val = 16'd0;
    endcase
  end

  // Parking skips an odd number of pulses when the two indexes differ in parity.
  assign ri_inc   = ri + IW'(1);
  assign left_odd = used[0] ^ ri[0];

  // Configuration and tape position registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_mode   <= 1'b0;
      init_level <= 1'b0;
      ri         <= '0;
      used       <= '0;
      psc        <= 32'd0;
      total      <= 32'd0;
      off        <= 32'd0;
      cur_level  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RECORD_MODE:   rec_mode   <= cfg_data;
          REG_INITIAL_LEVEL: init_level <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.rewind) begin
        ri        <= '0;
        psc       <= 32'd0;
        off       <= 32'd0;
        cur_level <= init_level;
        if (rec_mode) begin
          used  <= '0;
          total <= 32'd0;
        end
      end
      if (ctl.park) begin
        cur_level <= cur_level ^ left_odd;
        ri        <= used;
        psc       <= total;
        off       <= item_cycle - total;
      end
      if (ctl.put) begin
        ri        <= ri_inc;
        used      <= ri_inc;
        psc       <= psc + {16'd0, put_val};
        total     <= psc + {16'd0, put_val};
        cur_level <= ~cur_level;
      end
      if (ctl.step) begin
        ri        <= ri_inc;
        psc       <= psc + {16'd0, rd_data};
        cur_level <= ~cur_level;
      end
      if (ctl.set_off) begin
        off <= item_cycle - psc;
      end
    end
  end

  // Item capture, pulse length and output word.
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      item_cmd   <= cmd;
      item_cycle <= cycle;
      item_level <= level_in;
    end
    if (ctl.load_len) begin
      rem <= item_cycle - psc;
    end else if (ctl.sub_rem) begin
      rem <= rem - {16'd0, PULSE_MAX};
    end
    if (ctl.load_pairs) begin
      pairs <= pairs_calc;
    end
    if (ctl.load_out) begin
      level  <= cur_level;
      at_end <= ri >= used;
      status <= ctl.out_status;
    end
  end

  // Pulse store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctl.put) begin
      mem[ri[AW-1:0]] <= put_val;
    end
    rd_data <= mem[ri[AW-1:0]];
  end

  `TPRP_ASSERT_IMP(a_put_in_range, clk, rst, ctl.put, ri < IW'(STORE_DEPTH), "slot write past end")
  `TPRP_ASSERT_IMP(a_index_order, clk, rst, 1'b1, ri <= used, "read index past used length")
  `TPRP_ASSERT_IMP(a_step_inside, clk, rst, ctl.step, ri < used, "play step past stored end")

endmodule

### hdl/tprp_ctrl.sv
`include "tape_pulse_record_play_top_defines.svh"

module tprp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tprp_pkg::dp_stat_t stat,
  output tprp_pkg::dp_cmd_t  ctl
);
  import tprp_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [1:0] status_code;
  logic [1:0] status_code_next;
  logic       out_valid_next;
  logic       out_held;

  // State, status and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      status_code <= ST_OK;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      status_code <= status_code_next;
      out_valid   <= out_valid_next;
    end
  end

  assign in_stall = state != S_IDLE;

  // A finished item waits while the previous word is still stalled.
  assign out_held = (state == S_OUT) && out_valid && out_stall;

  // Next state and datapath commands.
  always_comb begin
    state_next       = state;
    status_code_next = status_code;
    out_valid_next   = out_valid;
    ctl              = '0;
    ctl.put_sel      = PUT_MAX;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in      = 1'b1;
          status_code_next = ST_OK;
          state_next       = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.load_len = 1'b1;
        if (stat.item_cmd == CMD_REWIND) begin
          ctl.rewind = 1'b1;
          state_next = S_OUT;
        end else if (stat.item_cmd == CMD_SAMPLE ||
                     (stat.item_cmd == CMD_FINISH && stat.rec_mode)) begin
          if (stat.back) begin
            status_code_next = ST_BACK;
            state_next       = S_OUT;
          end else if (stat.item_cmd == CMD_FINISH) begin
            state_next = S_PAIRS;
          end else if (stat.rec_mode) begin
            if (stat.lvl_diff) begin
              state_next = S_PAIRS;
            end else begin
              ctl.set_off = 1'b1;
              state_next  = S_OUT;
            end
          end else if (stat.past_end) begin
            ctl.park   = 1'b1;
            state_next = S_OUT;
          end else begin
            state_next = S_PRD;
          end
        end else begin
          // Unknown command, or finish while playing: no change.
          state_next = S_OUT;
        end
      end
      S_PAIRS: begin
        ctl.load_pairs = 1'b1;
        state_next     = S_ROOM;
      end
      S_ROOM: begin
        if (stat.room_ok) begin
          state_next = S_PUT_SEL;
        end else begin
          status_code_next = ST_FULL;
          state_next       = S_OUT;
        end
      end
      S_PUT_SEL: begin
        ctl.put = 1'b1;
        if (stat.rem_big) begin
          ctl.put_sel = PUT_MAX;
          state_next  = S_PUT_LO;
        end else begin
          ctl.put_sel = PUT_REM;
          state_next  = (stat.item_cmd == CMD_FINISH) ? S_PUT_ZERO : S_OFFSET;
        end
      end
      S_PUT_LO: begin
        ctl.put     = 1'b1;
        ctl.put_sel = PUT_ZERO;
        ctl.sub_rem = 1'b1;
        state_next  = S_PUT_SEL;
      end
      S_PUT_ZERO: begin
        ctl.put     = 1'b1;
        ctl.put_sel = PUT_ZERO;
        state_next  = S_OFFSET;
      end
      S_OFFSET: begin
        ctl.set_off = 1'b1;
        state_next  = S_OUT;
      end
      S_PRD: begin
        // Store read of the current slot lands at the next edge.
        state_next = S_PSTEP;
      end
      S_PSTEP: begin
        if (stat.step_ok) begin
          ctl.step   = 1'b1;
          state_next = S_PRD;
        end else begin
          ctl.set_off = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          ctl.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    ctl.out_status = status_code;
  end

  `TPRP_ASSERT_NXT(a_accept_check, clk, rst, in_valid && !in_stall, state == S_CHECK, "accept lost")
  `TPRP_ASSERT_NXT(a_out_wait, clk, rst, out_held, state == S_OUT, "word overrun")
  `TPRP_ASSERT_NXT(a_valid_src, clk, rst, !out_valid && state != S_OUT, !out_valid, "spurious word")

endmodule

### hdl/tape_pulse_record_play_top.sv
// Tape pulse store: plays back or records a square-wave tape signal kept as 16-bit pulse
// lengths in a single-port store of STORE_DEPTH slots. Each input word gives one result
// word. A rewind, an unknown command, a finish while playing, a recording sample with no
// level change, a parked play sample or a backwards sample goes straight to its result
// word; a play sample steps past one pulse at a time, since each step waits on the
// registered store read; a recorded level change counts the 0xFFFF,0 pairs of a long
// pulse, checks room and writes pairs and last pulse, and a finish the closing zero
// pulse too, since the store takes one slot write per cycle. A record sample or finish
// refused for a full store ends after the room check. While the previous result word is
// held by out_stall, the block waits in its last step while the stall lasts. The store
// is not cleared at reset; only slots below the used length feed a play step. Write
// record_mode and initial_level only while the block is idle.
module tape_pulse_record_play_top #(
  parameter int STORE_DEPTH = tprp_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tprp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd,
  input  logic [31:0]                    cycle,
  input  logic                           level_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           level,
  output logic                           at_end,
  output logic [1:0]                     status
);
  import tprp_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  // Sequencer.
  tprp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Store, position registers and output word.
  tprp_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .cycle     (cycle),
    .level_in  (level_in),
    .level     (level),
    .at_end    (at_end),
    .status    (status),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule
